// ===== sv/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int HASH_WORDS  = 8;
    localparam int ROUNDS      = 64;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;

    // Control for one byte cell of the block chain
    typedef struct packed {
        logic shift_byte;   // take the byte from the next cell (message load)
        logic shift_word;   // take the byte four cells up (schedule advance)
    } sha_bctl_t;

    // Control for one working-variable / hash cell
    typedef struct packed {
        logic load;         // copy hash word into working variable
        logic step;         // take the neighbor's value for one round
        logic add;          // fold working variable into hash word
        logic init;         // restart hash word from the initial value
    } sha_vctl_t;

    localparam logic [31:0] INIT_HASH [0:HASH_WORDS-1] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/sha_byte_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha_byte_cell (
    input  wire logic              clk,
    input  wire sha_pkg::sha_bctl_t ctl,
    input  wire logic [7:0]        next_byte,
    input  wire logic [7:0]        word_byte,
    output logic [7:0]             cell_byte
);
    import sha_pkg::*;

    logic [7:0] byte_reg;

    // Shift by one byte on load, by one word on a schedule round, else hold
    always_ff @(posedge clk)
    begin
        if (ctl.shift_byte)
        begin
            byte_reg <= next_byte;
        end
        else if (ctl.shift_word)
        begin
            byte_reg <= word_byte;
        end
    end

    assign cell_byte = byte_reg;

endmodule

`default_nettype wire

// ===== sv/sha_state_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha_state_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sha_pkg::sha_vctl_t ctl,
    input  wire logic [31:0]        init_word,
    input  wire logic [31:0]        round_in,
    output logic [31:0]             work_word,
    output logic [31:0]             hash_word
);
    import sha_pkg::*;

    logic [31:0] hash_reg;
    logic [31:0] work_reg;

    // Hash word: restart from the initial value, or accumulate after a block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= init_word;
        end
        else if (ctl.init)
        begin
            hash_reg <= init_word;
        end
        else if (ctl.add)
        begin
            hash_reg <= hash_reg + work_reg;
        end
    end

    // Working variable: load at block start, advance from the neighbor each round
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            work_reg <= hash_reg;
        end
        else if (ctl.step)
        begin
            work_reg <= round_in;
        end
    end

    assign work_word = work_reg;
    assign hash_word = hash_reg;

endmodule

`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 stream hasher. Message bytes enter one per transaction (byte_valid
// marks a real byte, last_byte closes the message; a last transaction with no
// byte is allowed, so an empty message works). The block buffer is a chain of
// 64 byte cells that also serves as the 16-word message schedule window, and
// the working variables are a chain of 8 word cells. While a block fills, one
// transaction is taken per cycle; after the transaction that completes a
// block, input is stalled while the cell chains run the 64 rounds and the
// result is folded into the hash words. Closing a message appends 9 to 72
// padding bytes, one per cycle from the current fill position, hashed in
// one or two block compressions. The digest then comes out as eight
// transactions, word 0 first, at one per cycle unless stalled; input stays
// stalled until the eighth word is taken, after which the hash restarts
// from the initial values.
module sha256_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [5:0] LAST_POS   = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS    = 6'(BLOCK_BYTES - 8);
    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(HASH_WORDS - 1);

    logic [2:0]  state_reg,     state_next;
    logic [5:0]  byte_cnt_reg,  byte_cnt_next;
    logic [60:0] count_reg,     count_next;
    logic [5:0]  rnd_reg,       rnd_next;
    logic [2:0]  idx_reg,       idx_next;
    logic        pend_last_reg, pend_last_next;
    logic        sent80_reg,    sent80_next;
    logic        len_act_reg,   len_act_next;
    logic        final_reg,     final_next;
    logic [63:0] len_sh_reg,    len_sh_next;

    logic        in_acc;
    logic        out_acc;
    logic        pad_len;
    logic [7:0]  pad_byte;
    logic        app;
    logic [7:0]  app_byte;
    logic        wrap;

    sha_bctl_t   bctl;
    sha_vctl_t   vctl;

    logic [7:0]  cell_q [0:BLOCK_BYTES-1];
    logic [31:0] work_q [0:HASH_WORDS-1];
    logic [31:0] hash_q [0:HASH_WORDS-1];

    logic [31:0] w0, w1, w9, w14;
    logic [31:0] new_w;
    logic [31:0] t1, t2;
    logic [31:0] new_a, new_e;

    // Handshake
    assign in_stall  = (state_reg != ST_LOAD);
    assign in_acc    = in_valid && (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_OUT);
    assign out_acc   = out_valid && !out_stall;

    // Padding byte: marker, zeros, then the big-endian bit length
    assign pad_len  = sent80_reg && (len_act_reg || (byte_cnt_reg == LEN_POS));
    assign pad_byte = !sent80_reg ? PAD_MARK : (pad_len ? len_sh_reg[63:56] : PAD_ZERO);

    // Byte append into the block chain
    assign app      = (in_acc && byte_valid) || (state_reg == ST_PAD);
    assign app_byte = (state_reg == ST_PAD) ? pad_byte : data_byte;
    assign wrap     = app && (byte_cnt_reg == LAST_POS);

    assign bctl.shift_byte = app;
    assign bctl.shift_word = (state_reg == ST_ROUND);

    assign vctl.load = wrap;
    assign vctl.step = (state_reg == ST_ROUND);
    assign vctl.add  = (state_reg == ST_FINAL);
    assign vctl.init = out_acc && (idx_reg == LAST_IDX);

    // Schedule window taps and the next schedule word
    assign w0  = {cell_q[0],  cell_q[1],  cell_q[2],  cell_q[3]};
    assign w1  = {cell_q[4],  cell_q[5],  cell_q[6],  cell_q[7]};
    assign w9  = {cell_q[36], cell_q[37], cell_q[38], cell_q[39]};
    assign w14 = {cell_q[56], cell_q[57], cell_q[58], cell_q[59]};
    assign new_w = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

    // Round function feeding the head cells of the two halves
    assign t1 = work_q[7] + big_sigma1(work_q[4])
              + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
              + ROUND_K[rnd_reg] + w0;
    assign t2 = big_sigma0(work_q[0])
              + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
    assign new_a = t1 + t2;
    assign new_e = work_q[3] + t1;

    // Block chain of byte cells
    for (genvar i = 0; i < BLOCK_BYTES; i++)
    begin : g_byte
        logic [7:0] nb;
        logic [7:0] wb;
        if (i == BLOCK_BYTES - 1)
        begin : g_tail
            assign nb = app_byte;
        end
        else
        begin : g_mid
            assign nb = cell_q[i+1];
        end
        if (i >= BLOCK_BYTES - 4)
        begin : g_new
            assign wb = new_w[8*(BLOCK_BYTES-1-i) +: 8];
        end
        else
        begin : g_shift
            assign wb = cell_q[i+4];
        end
        sha_byte_cell u_cell (
            .clk       (clk),
            .ctl       (bctl),
            .next_byte (nb),
            .word_byte (wb),
            .cell_byte (cell_q[i])
        );
    end

    // Working-variable chain of word cells
    for (genvar j = 0; j < HASH_WORDS; j++)
    begin : g_state
        logic [31:0] rin;
        if (j == 0)
        begin : g_a
            assign rin = new_a;
        end
        else if (j == 4)
        begin : g_e
            assign rin = new_e;
        end
        else
        begin : g_pass
            assign rin = work_q[j-1];
        end
        sha_state_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (vctl),
            .init_word (INIT_HASH[j]),
            .round_in  (rin),
            .work_word (work_q[j]),
            .hash_word (hash_q[j])
        );
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        byte_cnt_next  = byte_cnt_reg;
        count_next     = count_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        pend_last_next = pend_last_reg;
        sent80_next    = sent80_reg;
        len_act_next   = len_act_reg;
        final_next     = final_reg;
        len_sh_next    = len_sh_reg;

        if (app)
        begin
            byte_cnt_next = byte_cnt_reg + 6'd1;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (byte_valid)
                    begin
                        count_next = count_reg + 61'd1;
                    end
                    if (wrap)
                    begin
                        state_next     = ST_ROUND;
                        rnd_next       = '0;
                        pend_last_next = last_byte;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pend_last_next = 1'b0;
                if (!sent80_reg)
                begin
                    sent80_next = 1'b1;
                    len_sh_next = {count_reg, 3'b000};
                end
                else if (pad_len)
                begin
                    len_act_next = 1'b1;
                    len_sh_next  = {len_sh_reg[55:0], 8'h00};
                end
                if (wrap)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    final_next = pad_len;
                end
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (final_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else if (pend_last_reg || sent80_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next   = ST_LOAD;
                        count_next   = '0;
                        sent80_next  = 1'b0;
                        len_act_next = 1'b0;
                        final_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            byte_cnt_reg  <= '0;
            count_reg     <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            pend_last_reg <= 1'b0;
            sent80_reg    <= 1'b0;
            len_act_reg   <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            pend_last_reg <= pend_last_next;
            sent80_reg    <= sent80_next;
            len_act_reg   <= len_act_next;
            final_reg     <= final_next;
        end
    end

    // Hold the bit length for the closing bytes
    always_ff @(posedge clk)
    begin
        len_sh_reg <= len_sh_next;
    end

    // Digest word output
    assign digest_word = hash_q[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_IDX);

endmodule

`default_nettype wire
